// File: design/kca_pkg.sv
// kca_pkg: shared types for the keyed count aggregator.
// Holds the slot word carried between cells and the per-cycle cell control.
// No dependencies.
`timescale 1ns / 1ps

package kca_pkg;

    localparam int unsigned KeyW = 32;
    localparam int unsigned TotW = 32;

    // Contents of one table slot, as seen by the neighbor cell.
    typedef struct packed {
        logic                   used;
        logic [KeyW-1:0]        key;
        logic signed [TotW-1:0] total;
    } t_slot;

    // Control broadcast to every cell in the chain.
    typedef struct packed {
        logic ev_en;    // counted event this cycle
        logic any_hit;  // some cell already holds the key
        logic shift;    // drain step: take the next cell's slot
    } t_cell_ctl;

endpackage

// File: design/kca_cell.sv
// kca_cell: one slot of the aggregation table.
// Matches/accumulates on events and shifts toward the head during a flush.
// Depends on kca_pkg.
`timescale 1ns / 1ps

module kca_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kca_pkg::t_cell_ctl            i_ctl,
    input  logic [kca_pkg::KeyW-1:0]      i_id,
    input  logic signed [kca_pkg::TotW-1:0] i_amount,
    input  logic                          i_prev_used,
    input  kca_pkg::t_slot                i_next,
    output kca_pkg::t_slot                o_slot,
    output logic                          o_hit
);
    import kca_pkg::*;

    logic                   r_used, n_used;
    logic [KeyW-1:0]        r_key, n_key;
    logic signed [TotW-1:0] r_total, n_total;

    assign o_hit = r_used && (r_key == i_id);

    always_comb begin
        n_used  = r_used;
        n_key   = r_key;
        n_total = r_total;
        priority if (i_ctl.shift) begin
            n_used  = i_next.used;
            n_key   = i_next.key;
            n_total = i_next.total;
        end else if (i_ctl.ev_en) begin
            if (o_hit) begin
                n_total = r_total + i_amount;
            end else if (!i_ctl.any_hit && !r_used && i_prev_used) begin
                // first empty slot claims the new key
                n_used  = 1'b1;
                n_key   = i_id;
                n_total = i_amount;
            end
        end else begin
            // hold the slot
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
        r_key   <= n_key;
        r_total <= n_total;
    end

    assign o_slot = '{used: r_used, key: r_key, total: r_total};

endmodule

// File: design/keyed_count_aggregator_flush.sv
// keyed_count_aggregator_flush: per-key signed counters with periodic flush.
// Flush: the first flush record is valid in the cycle after the flushing word.
// Throughput: one word per cycle while counting; during a flush, input stays stalled
// until the sink has taken every filled slot (1..TABLE_SLOTS).
// Reset: synchronous active-low; clears slot used bits, event counter and drain state.
// Depends on kca_pkg and kca_cell.
`timescale 1ns / 1ps

module keyed_count_aggregator_flush #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [kca_pkg::KeyW-1:0]        i_process_id,
    input  logic signed [kca_pkg::TotW-1:0] i_amount,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kca_pkg::KeyW-1:0]        o_out_process_id,
    output logic signed [kca_pkg::TotW-1:0] o_out_total,
    output logic                            o_last_of_flush
);
    import kca_pkg::*;

    // Counter width; a single-slot table still needs a one-bit counter.
    localparam int unsigned CntW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Chain of slot cells. Filled slots always form a prefix, so a cell
    // knows it is the first empty slot from its left neighbor alone.
    t_slot                   w_slot [TABLE_SLOTS];
    t_slot                   w_next [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]  w_hit;
    t_cell_ctl               w_ctl;

    logic            r_drain, n_drain;
    logic [CntW-1:0] r_count, n_count;

    logic w_in_acc;
    logic w_out_acc;
    logic w_counted;
    logic w_flush;

    // Accept input only while not draining a flush.
    assign o_ready   = !r_drain;
    assign w_in_acc  = i_valid && o_ready;
    assign w_counted = w_in_acc && (i_process_id != '0);
    assign w_flush   = w_counted && (r_count == CntW'(TABLE_SLOTS - 1));

    // Head cell is the output register; each accepted record shifts the row.
    assign o_valid          = r_drain && w_slot[0].used;
    assign o_out_process_id = w_slot[0].key;
    assign o_out_total      = w_slot[0].total;
    assign o_last_of_flush  = !w_next[0].used;
    assign w_out_acc        = o_valid && i_ready;

    assign w_ctl = '{ev_en: w_counted, any_hit: |w_hit, shift: w_out_acc};

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        logic w_prev_used;

        if (g == 0) begin : g_head
            assign w_prev_used = 1'b1;
        end else begin : g_body
            assign w_prev_used = w_slot[g-1].used;
        end

        if (g == TABLE_SLOTS - 1) begin : g_tail
            assign w_next[g] = '0;
        end else begin : g_link
            assign w_next[g] = w_slot[g+1];
        end

        kca_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_id        (i_process_id),
            .i_amount    (i_amount),
            .i_prev_used (w_prev_used),
            .i_next      (w_next[g]),
            .o_slot      (w_slot[g]),
            .o_hit       (w_hit[g])
        );
    end

    always_comb begin
        n_drain = r_drain;
        n_count = r_count;
        priority if (w_out_acc && o_last_of_flush) begin
            // final record taken: drop back to counting
            n_drain = 1'b0;
        end else if (w_flush) begin
            // update lands this edge; start draining next cycle
            n_drain = 1'b1;
            n_count = '0;
        end else if (w_counted) begin
            n_count = r_count + CntW'(1);
        end else begin
            // hold drain state and count
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_count <= '0;
        end else begin
            r_drain <= n_drain;
            r_count <= n_count;
        end
    end

endmodule
